/* design/yuv_to_rgb_upsample_convert_defines.svh */
// ----------------------------------------------------------------------------
// yuv to rgb upsample convert: assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef YUV_TO_RGB_UPSAMPLE_CONVERT_DEFINES_SVH
`define YUV_TO_RGB_UPSAMPLE_CONVERT_DEFINES_SVH

// same-cycle implication
`define YRC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define YRC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/yrc_pkg.sv */
// ----------------------------------------------------------------------------
// yrc_pkg
// shared types and constants of the yuv to rgb upsample converter
// ----------------------------------------------------------------------------
package yrc_pkg;

  localparam int MAX_WIDTH_DEF      = 4096;
  localparam int COEF_FRAC_BITS_DEF = 10;
  localparam int ROW_LIMIT          = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int SIZE_W     = 13;
  localparam int STRIDE_W   = 14;
  localparam int ROW_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_HEIGHT = 3'd4;

  localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST   = 13'd640;
  localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST  = 13'd480;
  localparam logic [STRIDE_W-1:0] LUMA_STRIDE_RST   = 14'd640;
  localparam logic [STRIDE_W-1:0] CHROMA_STRIDE_RST = 14'd320;
  localparam logic [SIZE_W-1:0]   CHROMA_HEIGHT_RST = 13'd240;

  localparam logic [7:0] GREY_LEVEL = 8'd128;

  typedef enum logic [1:0] {
    FMT_UNKNOWN,
    FMT_444,
    FMT_422,
    FMT_420
  } fmt_t;

  typedef enum logic [1:0] {
    SRC_HOLD,
    SRC_INPUT,
    SRC_STORE
  } chroma_src_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       grey;
    logic       frame_end;
  } pix_t;

endpackage

/* design/yrc_line_store.sv */
// ----------------------------------------------------------------------------
// yrc_line_store
// chroma line memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module yrc_line_store #(
  parameter int DEPTH = 2048,
  parameter int A_W   = 11
) (
  input  logic           clk,
  input  logic           we,
  input  logic [A_W-1:0] waddr,
  input  logic [15:0]    wdata,
  input  logic           re,
  input  logic [A_W-1:0] raddr,
  output logic [15:0]    rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/yrc_matrix.sv */
// ----------------------------------------------------------------------------
// yrc_matrix
// colour matrix: products stage, then sum, round and clamp into the output
// ----------------------------------------------------------------------------
module yrc_matrix #(
  parameter int COEF_FRAC_BITS = yrc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  yrc_pkg::pix_t in_pix,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic          out_frame_end
);

  import yrc_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = COEF_FRAC_BITS + 10;
  localparam int ACC_W  = COEF_FRAC_BITS + 12;

  localparam logic signed [COEF_W-1:0] C_RU =
    COEF_W'(((956 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [COEF_W-1:0] C_RV =
    COEF_W'(((621 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [COEF_W-1:0] C_GU =
    COEF_W'(((272 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [COEF_W-1:0] C_GV =
    COEF_W'(((647 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [COEF_W-1:0] C_BU =
    COEF_W'(((1106 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [COEF_W-1:0] C_BV =
    COEF_W'(((1703 << COEF_FRAC_BITS) + 500) / 1000);

  function automatic logic [7:0] round_clamp(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0]                rnd;
    logic [ACC_W-COEF_FRAC_BITS-1:0] hi;
    rnd = $unsigned(acc) + (ACC_W'(1) << (COEF_FRAC_BITS - 1));
    hi  = rnd[ACC_W-1:COEF_FRAC_BITS];
    if (acc[ACC_W-1]) begin
      return 8'd0;
    end else if (|hi[ACC_W-COEF_FRAC_BITS-1:8]) begin
      return 8'd255;
    end else begin
      return hi[7:0];
    end
  endfunction

  logic signed [8:0]        u_s, v_s;
  logic                     v2_r, v3_r;
  logic                     adv2, adv3;
  logic [7:0]               luma_r;
  logic                     grey2_r, fend2_r;
  logic signed [PROD_W-1:0] p_ru_r, p_rv_r, p_gu_r, p_gv_r, p_bu_r, p_bv_r;
  logic signed [ACC_W-1:0]  base, acc_r, acc_g, acc_b;
  logic [7:0]               red_r, green_r, blue_r;
  logic                     fend3_r;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign in_ready = adv2;

  assign u_s = $signed({1'b0, in_pix.chroma_u}) - 9'sd128;
  assign v_s = $signed({1'b0, in_pix.chroma_v}) - 9'sd128;

  // products stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && in_valid) begin
      luma_r  <= in_pix.luma;
      grey2_r <= in_pix.grey;
      fend2_r <= in_pix.frame_end;
      p_ru_r  <= PROD_W'(C_RU * u_s);
      p_rv_r  <= PROD_W'(C_RV * v_s);
      p_gu_r  <= PROD_W'(C_GU * u_s);
      p_gv_r  <= PROD_W'(C_GV * v_s);
      p_bu_r  <= PROD_W'(C_BU * u_s);
      p_bv_r  <= PROD_W'(C_BV * v_s);
    end
  end

  // sum, round and clamp
  always_comb begin
    base  = $signed({{(ACC_W-8-COEF_FRAC_BITS){1'b0}}, luma_r, {COEF_FRAC_BITS{1'b0}}});
    acc_r = base + ACC_W'(p_ru_r) + ACC_W'(p_rv_r);
    acc_g = base - ACC_W'(p_gu_r) - ACC_W'(p_gv_r);
    acc_b = base + ACC_W'(p_bu_r) + ACC_W'(p_bv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      fend3_r <= fend2_r;
      if (grey2_r) begin
        red_r   <= GREY_LEVEL;
        green_r <= GREY_LEVEL;
        blue_r  <= GREY_LEVEL;
      end else begin
        red_r   <= round_clamp(acc_r);
        green_r <= round_clamp(acc_g);
        blue_r  <= round_clamp(acc_b);
      end
    end
  end

  assign out_valid     = v3_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_frame_end = fend3_r;

endmodule

/* design/yuv_to_rgb_upsample_convert.sv */
// ----------------------------------------------------------------------------
// yuv_to_rgb_upsample_convert: yuv to rgb with nearest-neighbour chroma
// path: the stage-one, products and output registers lie between in and out
// throughput: one pixel per cycle unless stalled; store: write and read port
// reset: synchronous active-low rst_n; control, counters, held chroma cleared
// ----------------------------------------------------------------------------
`include "yuv_to_rgb_upsample_convert_defines.svh"

module yuv_to_rgb_upsample_convert #(
  parameter int MAX_WIDTH      = yrc_pkg::MAX_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = yrc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_luma,
  input  logic [7:0]                     in_chroma_u,
  input  logic [7:0]                     in_chroma_v,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_frame_end,
  input  logic                           cfg_we,
  input  logic [yrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import yrc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SIZE_W-1:0]   frame_width_r, frame_height_r, chroma_height_r;
  logic [STRIDE_W-1:0] luma_stride_r, chroma_stride_r, half_stride;

  fmt_t              fmt;
  logic [W_W-1:0]    eff_width, col_inc;
  logic [SIZE_W-1:0] eff_height, row_inc;
  logic              row_end, frame_end;
  chroma_src_t       src;
  logic              in_acc;
  logic              store_we;
  logic [A_W-1:0]    slot;
  logic [15:0]       store_rdata;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic              v1_r, adv1;
  logic [7:0]        y_r, u_r, v_r;
  chroma_src_t       src_r;
  logic              grey_r, fend_r;
  logic [7:0]        held_u_r, held_v_r, held_u_nxt, held_v_nxt;
  logic [7:0]        cu, cv;

  pix_t              m_pix;
  logic              m_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      luma_stride_r   <= LUMA_STRIDE_RST;
      chroma_stride_r <= CHROMA_STRIDE_RST;
      chroma_height_r <= CHROMA_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[SIZE_W-1:0];
        REG_LUMA_STRIDE:   luma_stride_r   <= cfg_wdata[STRIDE_W-1:0];
        REG_CHROMA_STRIDE: chroma_stride_r <= cfg_wdata[STRIDE_W-1:0];
        REG_CHROMA_HEIGHT: chroma_height_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // format detection
  always_comb begin
    half_stride = luma_stride_r >> 1;
    if (chroma_stride_r == luma_stride_r && chroma_height_r == frame_height_r) begin
      fmt = FMT_444;
    end else if (chroma_stride_r == half_stride && chroma_height_r == frame_height_r) begin
      fmt = FMT_422;
    end else if (chroma_stride_r == half_stride &&
                 chroma_height_r == (frame_height_r >> 1)) begin
      fmt = FMT_420;
    end else begin
      fmt = FMT_UNKNOWN;
    end
  end

  // raster position
  always_comb begin
    if (frame_width_r == '0) begin
      eff_width = W_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      eff_width = W_W'(MAX_WIDTH);
    end else begin
      eff_width = W_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_height = SIZE_W'(1);
    end else if (frame_height_r > SIZE_W'(ROW_LIMIT)) begin
      eff_height = SIZE_W'(ROW_LIMIT);
    end else begin
      eff_height = frame_height_r;
    end
    col_inc   = W_W'(col_r) + W_W'(1);
    row_inc   = SIZE_W'(row_r) + SIZE_W'(1);
    row_end   = col_inc >= eff_width;
    frame_end = row_end && (row_inc >= eff_height);
    col_nxt   = row_end ? '0 : col_inc[COL_W-1:0];
    row_nxt   = row_end ? (frame_end ? '0 : row_inc[ROW_W-1:0]) : row_r;
  end

  // chroma source for this pixel
  always_comb begin
    src = SRC_HOLD;
    if (fmt != FMT_UNKNOWN && (fmt == FMT_444 || !col_r[0])) begin
      src = (fmt == FMT_420 && row_r[0]) ? SRC_STORE : SRC_INPUT;
    end
  end

  assign adv1     = !v1_r || m_ready;
  assign in_ready = adv1;
  assign in_acc   = in_valid && in_ready;
  assign slot     = A_W'(col_r >> 1);
  assign store_we = in_acc && fmt == FMT_420 && !col_r[0] && !row_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  yrc_line_store #(
    .DEPTH (DEPTH),
    .A_W   (A_W)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (slot),
    .wdata ({in_chroma_u, in_chroma_v}),
    .re    (in_acc),
    .raddr (slot),
    .rdata (store_rdata)
  );

  // stage one: chroma selection against the held pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      y_r    <= in_luma;
      u_r    <= in_chroma_u;
      v_r    <= in_chroma_v;
      src_r  <= src;
      grey_r <= (fmt == FMT_UNKNOWN);
      fend_r <= frame_end;
    end
  end

  always_comb begin
    case (src_r)
      SRC_INPUT: begin
        cu = u_r;
        cv = v_r;
      end
      SRC_STORE: begin
        cu = store_rdata[15:8];
        cv = store_rdata[7:0];
      end
      default: begin
        cu = held_u_r;
        cv = held_v_r;
      end
    endcase
    held_u_nxt = (v1_r && m_ready) ? cu : held_u_r;
    held_v_nxt = (v1_r && m_ready) ? cv : held_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_u_r <= '0;
      held_v_r <= '0;
    end else begin
      held_u_r <= held_u_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  assign m_pix = '{luma: y_r, chroma_u: cu, chroma_v: cv, grey: grey_r, frame_end: fend_r};

  yrc_matrix #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_matrix (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (v1_r),
    .in_ready      (m_ready),
    .in_pix        (m_pix),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

  `YRC_ASSERT_NXT(a_row_wrap, in_acc && row_end, col_r == '0, "column count missed row end")
  `YRC_ASSERT_NXT(a_s1_hold, v1_r && !m_ready, v1_r && $stable(y_r) && $stable(src_r), "stage one lost a stalled transaction")
  `YRC_ASSERT_NXT(a_held_still, !(v1_r && m_ready), $stable(held_u_r) && $stable(held_v_r), "held chroma moved without a transaction")
  `YRC_ASSERT_IMP(a_store_wr_src, store_we, src == SRC_INPUT, "line store written on a pixel not taking new chroma")

endmodule
